@@ hdl/bbc_pkg.sv @@
package bbc_pkg;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_POP_RD,
        S_FLUSH_RD,
        S_FLUSH_OUT,
        S_RESULT
    } t_state;

    // Result kinds
    localparam logic [1:0] KIND_UNMATCHED  = 2'd0;
    localparam logic [1:0] KIND_UNTERM     = 2'd1;
    localparam logic [1:0] KIND_OVERFLOW   = 2'd2;
    localparam logic [1:0] KIND_DONE       = 2'd3;

    // Bracket types
    localparam logic [1:0] TYPE_ROUND      = 2'd0;
    localparam logic [1:0] TYPE_CURLY      = 2'd1;
    localparam logic [1:0] TYPE_SQUARE     = 2'd2;

    // Characters of interest
    localparam logic [7:0] CH_LPAREN    = 8'h28;
    localparam logic [7:0] CH_LBRACE    = 8'h7B;
    localparam logic [7:0] CH_LBRACKET  = 8'h5B;
    localparam logic [7:0] CH_RPAREN    = 8'h29;
    localparam logic [7:0] CH_RBRACE    = 8'h7D;
    localparam logic [7:0] CH_RBRACKET  = 8'h5D;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_STAR      = 8'h2A;

    // Controller to datapath
    typedef struct packed {
        logic byte_step;    // take the input byte
        logic eot_start;    // end of text: clear scanner, start flush at entry 0
        logic pop;          // closer matched the top entry
        logic load_flush;   // load an unterminated-opener result from the stack
        logic flush_next;   // advance flush index, read next entry
        logic load_done;    // load the done result, empty the stack
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic eot;          // input word is an end-of-text marker
        logic byte_result;  // input byte gives a result at once
        logic closer_check; // input byte is a closer to test against the top
        logic top_match;    // stack top type equals the held closer type
        logic stack_empty;
        logic flush_last;   // flush index is at the newest entry
    } t_sts;

endpackage

@@ hdl/bbc_in_if.sv @@
interface bbc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       end_of_text;

    modport source (output valid, output text_byte, output end_of_text, input ready);
    modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

@@ hdl/bbc_out_if.sv @@
interface bbc_out_if #(
    parameter int LINE_BITS   = 16,
    parameter int COLUMN_BITS = 12
);
    logic                   valid;
    logic                   ready;
    logic [1:0]             kind;
    logic [1:0]             bracket_type;
    logic [LINE_BITS-1:0]   line_number;
    logic [COLUMN_BITS-1:0] column_number;
    logic                   last_result;

    modport source (output valid, output kind, output bracket_type, output line_number,
                    output column_number, output last_result, input ready);
    modport sink   (input valid, input kind, input bracket_type, input line_number,
                    input column_number, input last_result, output ready);
endinterface

@@ hdl/bbc_ram.sv @@
module bbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/bbc_datapath.sv @@
module bbc_datapath #(
    parameter int STACK_DEPTH = 32,
    parameter int LINE_BITS   = 16,
    parameter int COLUMN_BITS = 12
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  bbc_pkg::t_cmd          i_cmd,
    output bbc_pkg::t_sts          o_sts,
    input  logic [7:0]             i_text_byte,
    input  logic                   i_end_of_text,
    output logic [1:0]             o_kind,
    output logic [1:0]             o_bracket_type,
    output logic [LINE_BITS-1:0]   o_line_number,
    output logic [COLUMN_BITS-1:0] o_column_number,
    output logic                   o_last_result
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int EW = 2 + LINE_BITS + COLUMN_BITS;
    localparam logic [CW-1:0] FULL = CW'(STACK_DEPTH);

    // Scanner state
    logic                   r_in_string, n_in_string;
    logic                   r_in_line, n_in_line;
    logic                   r_in_block, n_in_block;
    logic                   r_pend_slash, n_pend_slash;
    logic                   r_pend_star, n_pend_star;
    logic [7:0]             r_prev, n_prev;
    logic [LINE_BITS-1:0]   r_line, n_line;
    logic [COLUMN_BITS-1:0] r_col, n_col;
    logic [CW-1:0]          r_count, n_count;
    logic [CW-1:0]          r_idx, n_idx;

    // Result register
    logic [1:0]             r_kind, n_kind;
    logic [1:0]             r_type, n_type;
    logic [LINE_BITS-1:0]   r_res_line, n_res_line;
    logic [COLUMN_BITS-1:0] r_res_col, n_res_col;
    logic                   r_last, n_last;

    // Byte decode
    logic                   is_open, is_close, active, res_now, chk_now, push;
    logic [1:0]             br_type;
    logic [AW-1:0]          raddr;
    logic [EW-1:0]          rdata;
    logic [CW-1:0]          idx_inc;

    assign idx_inc = r_idx + CW'(1);

    always_comb begin
        is_open  = 1'b0;
        is_close = 1'b0;
        br_type  = bbc_pkg::TYPE_ROUND;
        case (i_text_byte)
            bbc_pkg::CH_LPAREN:   begin is_open  = 1'b1; br_type = bbc_pkg::TYPE_ROUND;  end
            bbc_pkg::CH_LBRACE:   begin is_open  = 1'b1; br_type = bbc_pkg::TYPE_CURLY;  end
            bbc_pkg::CH_LBRACKET: begin is_open  = 1'b1; br_type = bbc_pkg::TYPE_SQUARE; end
            bbc_pkg::CH_RPAREN:   begin is_close = 1'b1; br_type = bbc_pkg::TYPE_ROUND;  end
            bbc_pkg::CH_RBRACE:   begin is_close = 1'b1; br_type = bbc_pkg::TYPE_CURLY;  end
            bbc_pkg::CH_RBRACKET: begin is_close = 1'b1; br_type = bbc_pkg::TYPE_SQUARE; end
            default: ;
        endcase
    end

    // Plain text not swallowed by a comment start
    assign active = (i_text_byte != bbc_pkg::CH_NEWLINE) && !r_in_string && !r_in_line
                    && !r_in_block
                    && !(r_pend_slash && (i_text_byte == bbc_pkg::CH_SLASH
                                          || i_text_byte == bbc_pkg::CH_STAR));
    assign push    = active && is_open && (r_count != FULL);
    assign res_now = active && ((is_open && r_count == FULL) || (is_close && r_count == '0));
    assign chk_now = active && is_close && (r_count != '0);

    // Scanner and stack bookkeeping
    always_comb begin
        n_in_string  = r_in_string;
        n_in_line    = r_in_line;
        n_in_block   = r_in_block;
        n_pend_slash = r_pend_slash;
        n_pend_star  = r_pend_star;
        n_prev       = r_prev;
        n_line       = r_line;
        n_col        = r_col;
        n_count      = r_count;
        n_idx        = r_idx;
        n_kind       = r_kind;
        n_type       = r_type;
        n_res_line   = r_res_line;
        n_res_col    = r_res_col;
        n_last       = r_last;

        if (i_cmd.byte_step) begin
            n_prev = i_text_byte;
            if (i_text_byte == bbc_pkg::CH_NEWLINE) begin
                if (r_line != '1) n_line = r_line + LINE_BITS'(1);
                n_col        = '0;
                n_in_line    = 1'b0;
                n_pend_slash = 1'b0;
                n_pend_star  = 1'b0;
            end else begin
                if (r_col != '1) n_col = r_col + COLUMN_BITS'(1);
                if (r_in_string) begin
                    if (i_text_byte == bbc_pkg::CH_QUOTE && r_prev != bbc_pkg::CH_BACKSLASH)
                        n_in_string = 1'b0;
                end else if (r_in_line) begin
                    n_in_line = 1'b1;
                end else if (r_in_block) begin
                    if (r_pend_star && i_text_byte == bbc_pkg::CH_SLASH) begin
                        n_in_block  = 1'b0;
                        n_pend_star = 1'b0;
                    end else begin
                        n_pend_star = (i_text_byte == bbc_pkg::CH_STAR);
                    end
                end else begin
                    n_pend_slash = 1'b0;
                    if (r_pend_slash && i_text_byte == bbc_pkg::CH_SLASH) begin
                        n_in_line = 1'b1;
                    end else if (r_pend_slash && i_text_byte == bbc_pkg::CH_STAR) begin
                        n_in_block  = 1'b1;
                        n_pend_star = 1'b0;
                    end else if (i_text_byte == bbc_pkg::CH_QUOTE) begin
                        n_in_string = 1'b1;
                    end else if (i_text_byte == bbc_pkg::CH_SLASH) begin
                        n_pend_slash = 1'b1;
                    end
                end
            end
            if (push) n_count = r_count + CW'(1);
            // capture the bracket for a possible result
            if (active && (is_open || is_close)) begin
                n_kind     = is_open ? bbc_pkg::KIND_OVERFLOW : bbc_pkg::KIND_UNMATCHED;
                n_type     = br_type;
                n_res_line = r_line;
                n_res_col  = r_col;
                n_last     = 1'b1;
            end
        end

        if (i_cmd.pop) n_count = r_count - CW'(1);

        if (i_cmd.eot_start) begin
            n_in_string  = 1'b0;
            n_in_line    = 1'b0;
            n_in_block   = 1'b0;
            n_pend_slash = 1'b0;
            n_pend_star  = 1'b0;
            n_prev       = '0;
            n_line       = '0;
            n_col        = '0;
            n_idx        = '0;
        end

        if (i_cmd.flush_next) n_idx = idx_inc;

        if (i_cmd.load_flush) begin
            n_kind     = bbc_pkg::KIND_UNTERM;
            n_type     = rdata[EW-1 -: 2];
            n_res_line = rdata[COLUMN_BITS +: LINE_BITS];
            n_res_col  = rdata[COLUMN_BITS-1:0];
            n_last     = 1'b0;
        end

        if (i_cmd.load_done) begin
            n_kind     = bbc_pkg::KIND_DONE;
            n_type     = bbc_pkg::TYPE_ROUND;
            n_res_line = '0;
            n_res_col  = '0;
            n_last     = 1'b1;
            n_count    = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_string  <= 1'b0;
            r_in_line    <= 1'b0;
            r_in_block   <= 1'b0;
            r_pend_slash <= 1'b0;
            r_pend_star  <= 1'b0;
            r_prev       <= '0;
            r_line       <= '0;
            r_col        <= '0;
            r_count      <= '0;
            r_idx        <= '0;
        end else begin
            r_in_string  <= n_in_string;
            r_in_line    <= n_in_line;
            r_in_block   <= n_in_block;
            r_pend_slash <= n_pend_slash;
            r_pend_star  <= n_pend_star;
            r_prev       <= n_prev;
            r_line       <= n_line;
            r_col        <= n_col;
            r_count      <= n_count;
            r_idx        <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind     <= n_kind;
        r_type     <= n_type;
        r_res_line <= n_res_line;
        r_res_col  <= n_res_col;
        r_last     <= n_last;
    end

    // Read address: flush start, flush step, or the stack top
    always_comb begin
        if (i_cmd.eot_start) begin
            raddr = '0;
        end else if (i_cmd.flush_next) begin
            raddr = idx_inc[AW-1:0];
        end else begin
            raddr = AW'(r_count - CW'(1));
        end
    end

    bbc_ram #(
        .WIDTH (EW),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (i_cmd.byte_step && push),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata ({br_type, r_line, r_col}),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // Status to controller
    always_comb begin
        o_sts.eot          = i_end_of_text;
        o_sts.byte_result  = res_now;
        o_sts.closer_check = chk_now;
        o_sts.top_match    = (rdata[EW-1 -: 2] == r_type);
        o_sts.stack_empty  = (r_count == '0);
        o_sts.flush_last   = (idx_inc == r_count);
    end

    assign o_kind          = r_kind;
    assign o_bracket_type  = r_type;
    assign o_line_number   = r_res_line;
    assign o_column_number = r_res_col;
    assign o_last_result   = r_last;

endmodule

@@ hdl/bbc_ctrl.sv @@
module bbc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  bbc_pkg::t_sts i_sts,
    output bbc_pkg::t_cmd o_cmd
);

    bbc_pkg::t_state r_state, n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bbc_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            bbc_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_sts.eot) begin
                        o_cmd.eot_start = 1'b1;
                        if (i_sts.stack_empty) begin
                            o_cmd.load_done = 1'b1;
                            n_state = bbc_pkg::S_RESULT;
                        end else begin
                            n_state = bbc_pkg::S_FLUSH_RD;
                        end
                    end else begin
                        o_cmd.byte_step = 1'b1;
                        if (i_sts.byte_result) begin
                            n_state = bbc_pkg::S_RESULT;
                        end else if (i_sts.closer_check) begin
                            n_state = bbc_pkg::S_POP_RD;
                        end
                    end
                end
            end
            bbc_pkg::S_POP_RD: begin
                if (i_sts.top_match) begin
                    o_cmd.pop = 1'b1;
                    n_state = bbc_pkg::S_IDLE;
                end else begin
                    n_state = bbc_pkg::S_RESULT;
                end
            end
            bbc_pkg::S_FLUSH_RD: begin
                o_cmd.load_flush = 1'b1;
                n_state = bbc_pkg::S_FLUSH_OUT;
            end
            bbc_pkg::S_FLUSH_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    if (i_sts.flush_last) begin
                        o_cmd.load_done = 1'b1;
                        n_state = bbc_pkg::S_RESULT;
                    end else begin
                        o_cmd.flush_next = 1'b1;
                        n_state = bbc_pkg::S_FLUSH_RD;
                    end
                end
            end
            bbc_pkg::S_RESULT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) n_state = bbc_pkg::S_IDLE;
            end
            default: n_state = bbc_pkg::S_IDLE;
        endcase
    end

endmodule

@@ hdl/bracket_balance_checker.sv @@
// Bracket balance checker: takes source text one byte per word on i_text and reports
// bracket errors on o_result. Strings and both comment styles are skipped. An ordinary
// byte leaves the checker ready for the next one; a closer that meets a non-empty stack
// also passes a pop-check state, as the stack top comes from the stack RAM's registered
// read port. A word that gives a result holds the input until the result is taken. An
// end-of-text word reports each open bracket oldest first (per entry a RAM read, then an
// output word) and then a done word; the block then starts over from its reset state.
module bracket_balance_checker #(
    parameter int STACK_DEPTH = 32,
    parameter int LINE_BITS   = 16,
    parameter int COLUMN_BITS = 12
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bbc_in_if.sink    i_text,
    bbc_out_if.source o_result
);

    bbc_pkg::t_cmd cmd;
    bbc_pkg::t_sts sts;

    bbc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_text.valid),
        .o_in_ready  (i_text.ready),
        .o_out_valid (o_result.valid),
        .i_out_ready (o_result.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    bbc_datapath #(
        .STACK_DEPTH (STACK_DEPTH),
        .LINE_BITS   (LINE_BITS),
        .COLUMN_BITS (COLUMN_BITS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_text_byte     (i_text.text_byte),
        .i_end_of_text   (i_text.end_of_text),
        .o_kind          (o_result.kind),
        .o_bracket_type  (o_result.bracket_type),
        .o_line_number   (o_result.line_number),
        .o_column_number (o_result.column_number),
        .o_last_result   (o_result.last_result)
    );

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps

module tb;

    localparam int LINE_W      = 16;
    localparam int COL_W       = 12;
    localparam int DEPTH       = 32;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_WAIT  = 100;

    typedef struct packed {
        logic [1:0]       kind;
        logic [1:0]       btype;
        logic [LINE_W-1:0] line;
        logic [COL_W-1:0]  col;
        logic             last;
    } t_bracket_report;

    // Tracks the scanner state of the text and the reports it should give
    class bracket_tracker;
        bit                in_string;
        bit                in_line_cmt;
        bit                in_block_cmt;
        bit                slash_seen;
        bit                star_seen;
        logic [7:0]        prev_byte;
        logic [LINE_W-1:0] line_pos;
        logic [COL_W-1:0]  col_pos;
        logic [1:0]        open_type [DEPTH];
        logic [LINE_W-1:0] open_line [DEPTH];
        logic [COL_W-1:0]  open_col  [DEPTH];
        int                depth_used;
        t_bracket_report   expected_reports [$];
        int                mismatches;
        int                reports_checked;

        function new();
            clear_scan();
            mismatches      = 0;
            reports_checked = 0;
        endfunction

        function void clear_scan();
            in_string    = 0;
            in_line_cmt  = 0;
            in_block_cmt = 0;
            slash_seen   = 0;
            star_seen    = 0;
            prev_byte    = '0;
            line_pos     = '0;
            col_pos      = '0;
            depth_used   = 0;
        endfunction

        function void add_report(logic [1:0] kind, logic [1:0] btype,
                                 logic [LINE_W-1:0] line, logic [COL_W-1:0] col,
                                 logic last);
            t_bracket_report rep;
            rep = '{kind: kind, btype: btype, line: line, col: col, last: last};
            expected_reports.insert(expected_reports.size(), rep);
        endfunction

        // Advance the scanner by one accepted word
        function void predict_reports(logic [7:0] b, logic eot);
            bit         taken;
            bit         is_open;
            bit         is_close;
            logic [1:0] btype;
            if (eot) begin
                for (int i = 0; i < depth_used; i++)
                    add_report(bbc_pkg::KIND_UNTERM, open_type[i], open_line[i], open_col[i],
                               1'b0);
                add_report(bbc_pkg::KIND_DONE, bbc_pkg::TYPE_ROUND, '0, '0, 1'b1);
                clear_scan();
                return;
            end
            // newline ends line comments and clears both pending marks
            if (b == bbc_pkg::CH_NEWLINE) begin
                if (line_pos != {LINE_W{1'b1}})
                    line_pos++;
                col_pos     = '0;
                in_line_cmt = 0;
                slash_seen  = 0;
                star_seen   = 0;
                prev_byte   = b;
                return;
            end
            if (in_string) begin
                if (b == bbc_pkg::CH_QUOTE && prev_byte != bbc_pkg::CH_BACKSLASH)
                    in_string = 0;
            end else if (in_line_cmt) begin
                // skipped up to newline
            end else if (in_block_cmt) begin
                if (star_seen && b == bbc_pkg::CH_SLASH) begin
                    in_block_cmt = 0;
                    star_seen    = 0;
                end else begin
                    star_seen = (b == bbc_pkg::CH_STAR);
                end
            end else begin
                taken = 0;
                if (slash_seen) begin
                    slash_seen = 0;
                    if (b == bbc_pkg::CH_SLASH) begin
                        in_line_cmt = 1;
                        taken       = 1;
                    end else if (b == bbc_pkg::CH_STAR) begin
                        in_block_cmt = 1;
                        star_seen    = 0;
                        taken        = 1;
                    end
                end
                if (!taken) begin
                    is_open  = 0;
                    is_close = 0;
                    btype    = bbc_pkg::TYPE_ROUND;
                    case (b)
                        bbc_pkg::CH_LPAREN: begin
                            is_open = 1; btype = bbc_pkg::TYPE_ROUND;
                        end
                        bbc_pkg::CH_LBRACE: begin
                            is_open = 1; btype = bbc_pkg::TYPE_CURLY;
                        end
                        bbc_pkg::CH_LBRACKET: begin
                            is_open = 1; btype = bbc_pkg::TYPE_SQUARE;
                        end
                        bbc_pkg::CH_RPAREN: begin
                            is_close = 1; btype = bbc_pkg::TYPE_ROUND;
                        end
                        bbc_pkg::CH_RBRACE: begin
                            is_close = 1; btype = bbc_pkg::TYPE_CURLY;
                        end
                        bbc_pkg::CH_RBRACKET: begin
                            is_close = 1; btype = bbc_pkg::TYPE_SQUARE;
                        end
                        default: ;
                    endcase
                    if (b == bbc_pkg::CH_QUOTE) begin
                        in_string = 1;
                    end else if (b == bbc_pkg::CH_SLASH) begin
                        slash_seen = 1;
                    end else if (is_open) begin
                        if (depth_used == DEPTH) begin
                            add_report(bbc_pkg::KIND_OVERFLOW, btype, line_pos, col_pos, 1'b1);
                        end else begin
                            open_type[depth_used] = btype;
                            open_line[depth_used] = line_pos;
                            open_col[depth_used]  = col_pos;
                            depth_used++;
                        end
                    end else if (is_close) begin
                        if (depth_used == 0 || open_type[depth_used-1] != btype)
                            add_report(bbc_pkg::KIND_UNMATCHED, btype, line_pos, col_pos, 1'b1);
                        else
                            depth_used--;
                    end
                end
            end
            if (col_pos != {COL_W{1'b1}})
                col_pos++;
            prev_byte = b;
        endfunction

        // Compare one taken report with the oldest expected one
        function void check_report(t_bracket_report got);
            t_bracket_report exp;
            bit              bad;
            reports_checked++;
            if (expected_reports.size() == 0) begin
                $error("report with none expected: kind %0d type %0d line %0d col %0d",
                       got.kind, got.btype, got.line, got.col);
                mismatches++;
                return;
            end
            exp = expected_reports.pop_front();
            bad = 0;
            if (got.kind !== exp.kind) begin
                $error("kind: expected %0d, actual %0d", exp.kind, got.kind);
                bad = 1;
            end
            if (got.btype !== exp.btype) begin
                $error("bracket_type: expected %0d, actual %0d", exp.btype, got.btype);
                bad = 1;
            end
            if (got.line !== exp.line) begin
                $error("line_number: expected %0d, actual %0d", exp.line, got.line);
                bad = 1;
            end
            if (got.col !== exp.col) begin
                $error("column_number: expected %0d, actual %0d", exp.col, got.col);
                bad = 1;
            end
            if (got.last !== exp.last) begin
                $error("last_result: expected %0d, actual %0d", exp.last, got.last);
                bad = 1;
            end
            if (bad)
                mismatches++;
        endfunction

        function bit drained();
            return expected_reports.size() == 0;
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    int   send_idle_pct;
    int   recv_idle_pct;
    int   words_sent;
    int   cycle_count;

    bracket_tracker tracker = new();

    bbc_in_if text_if();
    bbc_out_if #(.LINE_BITS(LINE_W), .COLUMN_BITS(COL_W)) result_if();

    bracket_balance_checker #(
        .STACK_DEPTH (DEPTH),
        .LINE_BITS   (LINE_W),
        .COLUMN_BITS (COL_W)
    ) u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_text   (text_if),
        .o_result (result_if)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // Cycle limit
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Receiver stalls
    always @(negedge i_clk) begin
        result_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Both handshakes seen at the same edge: the input word is noted first
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (text_if.valid && text_if.ready)
                tracker.predict_reports(text_if.text_byte, text_if.end_of_text);
            if (result_if.valid && result_if.ready)
                tracker.check_report('{kind: result_if.kind, btype: result_if.bracket_type,
                                       line: result_if.line_number,
                                       col: result_if.column_number,
                                       last: result_if.last_result});
        end
    end

    // Send one word, with random idle cycles ahead of it
    task automatic send_word(input logic [7:0] b, input logic eot);
        while ($urandom_range(99) < send_idle_pct) begin
            text_if.valid     <= 1'b0;
            text_if.text_byte <= 8'($urandom);
            @(negedge i_clk);
        end
        text_if.valid       <= 1'b1;
        text_if.text_byte   <= b;
        text_if.end_of_text <= eot;
        @(posedge i_clk);
        while (!text_if.ready)
            @(posedge i_clk);
        words_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_word(s[i], 1'b0);
    endtask

    task automatic end_text();
        send_word(8'($urandom), 1'b1);
    endtask

    task automatic wait_drained();
        while (!tracker.drained())
            @(negedge i_clk);
    endtask

    function automatic logic [7:0] opener_of(logic [1:0] t);
        case (t)
            bbc_pkg::TYPE_CURLY:  return bbc_pkg::CH_LBRACE;
            bbc_pkg::TYPE_SQUARE: return bbc_pkg::CH_LBRACKET;
            default:              return bbc_pkg::CH_LPAREN;
        endcase
    endfunction

    function automatic logic [7:0] closer_of(logic [1:0] t);
        case (t)
            bbc_pkg::TYPE_CURLY:  return bbc_pkg::CH_RBRACE;
            bbc_pkg::TYPE_SQUARE: return bbc_pkg::CH_RBRACKET;
            default:              return bbc_pkg::CH_RPAREN;
        endcase
    endfunction

    // Mostly well-nested text with strings and comments, some noise, then end of text
    task automatic send_random_text();
        logic [1:0] nest [$];
        logic [1:0] t;
        int         n_tok;
        int         pick;
        int         len;
        n_tok = $urandom_range(3, 30);
        for (int k = 0; k < n_tok; k++) begin
            pick = $urandom_range(99);
            if (pick < 24) begin
                t = 2'($urandom_range(2));
                nest.insert(nest.size(), t);
                send_word(opener_of(t), 1'b0);
            end else if (pick < 44) begin
                if (nest.size() != 0 && $urandom_range(99) < 85) begin
                    t = nest[nest.size()-1];
                    nest.delete(nest.size()-1);
                    send_word(closer_of(t), 1'b0);
                end else begin
                    send_word(closer_of(2'($urandom_range(2))), 1'b0);
                end
            end else if (pick < 51) begin
                send_word(bbc_pkg::CH_NEWLINE, 1'b0);
            end else if (pick < 59) begin
                // string, sometimes with escaped characters
                send_word(bbc_pkg::CH_QUOTE, 1'b0);
                len = $urandom_range(0, 6);
                for (int j = 0; j < len; j++) begin
                    if ($urandom_range(4) == 0) begin
                        send_word(bbc_pkg::CH_BACKSLASH, 1'b0);
                        send_word($urandom_range(3) == 0 ? bbc_pkg::CH_QUOTE
                                                         : 8'($urandom_range(32, 126)), 1'b0);
                    end else begin
                        send_word(8'($urandom_range(32, 126)), 1'b0);
                    end
                end
                send_word(bbc_pkg::CH_QUOTE, 1'b0);
            end else if (pick < 65) begin
                send_word(bbc_pkg::CH_SLASH, 1'b0);
                send_word(bbc_pkg::CH_SLASH, 1'b0);
                len = $urandom_range(0, 5);
                for (int j = 0; j < len; j++)
                    send_word(8'($urandom), 1'b0);
                send_word(bbc_pkg::CH_NEWLINE, 1'b0);
            end else if (pick < 71) begin
                send_word(bbc_pkg::CH_SLASH, 1'b0);
                send_word(bbc_pkg::CH_STAR, 1'b0);
                len = $urandom_range(0, 6);
                for (int j = 0; j < len; j++) begin
                    case ($urandom_range(4))
                        0: send_word(bbc_pkg::CH_STAR, 1'b0);
                        1: send_word(bbc_pkg::CH_SLASH, 1'b0);
                        2: send_word(bbc_pkg::CH_NEWLINE, 1'b0);
                        3: send_word(closer_of(2'($urandom_range(2))), 1'b0);
                        default: send_word(opener_of(2'($urandom_range(2))), 1'b0);
                    endcase
                end
                send_word(bbc_pkg::CH_STAR, 1'b0);
                send_word(bbc_pkg::CH_SLASH, 1'b0);
            end else if (pick < 76) begin
                send_word(bbc_pkg::CH_SLASH, 1'b0);
                send_word(8'($urandom_range(32, 126)), 1'b0);
            end else if (pick < 90) begin
                send_word(8'($urandom_range(97, 122)), 1'b0);
            end else begin
                send_word(8'($urandom), 1'b0);
            end
        end
        // now and then send a run of openers near or past the stack depth
        if ($urandom_range(19) == 0) begin
            len = $urandom_range(DEPTH - 2, DEPTH + 6);
            for (int j = 0; j < len; j++)
                send_word(opener_of(2'($urandom_range(2))), 1'b0);
        end
        end_text();
    endtask

    task automatic run_random(input int word_goal, input int report_goal);
        int words_start;
        int reports_start;
        words_start   = words_sent;
        reports_start = tracker.reports_checked;
        while (words_sent - words_start < word_goal ||
               tracker.reports_checked - reports_start < report_goal)
            send_random_text();
    endtask

    initial begin
        i_rst_n             = 1'b0;
        text_if.valid       = 1'b0;
        text_if.text_byte   = '0;
        text_if.end_of_text = 1'b0;
        result_if.ready     = 1'b0;
        words_sent          = 0;
        send_idle_pct       = 13;
        recv_idle_pct       = 76;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        // quote at start of text, opener hidden in a string, unmatched closer
        send_text("\"(\"){[");
        end_text();
        // escaped quote inside a string; backslash-quote outside opens one
        send_text("\"\\\"(\")\\\"]\"");
        end_text();
        // lone slash, block comment, line comment, newline clearing a pending slash
        send_text("/(/)x/*)*/]/***/{//(\n/\n[*/}");
        send_word(8'hFF, 1'b1);
        // byte extremes and wrong kind of closer
        send_word(8'h00, 1'b0);
        send_word(8'hFF, 1'b0);
        send_text("(]");
        end_text();
        // full stack: one opener past the depth, then flush every entry
        for (int i = 0; i <= DEPTH; i++)
            send_word(opener_of(2'(i % 3)), 1'b0);
        send_text("[)");
        end_text();

        run_random(120, 20);
        text_if.valid <= 1'b0;
        wait_drained();

        send_idle_pct = 76;
        recv_idle_pct = 13;
        run_random(120, 20);
        text_if.valid <= 1'b0;
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(120, 20);

        text_if.valid <= 1'b0;
        wait_drained();
        repeat (DRAIN_WAIT) @(negedge i_clk);

        if (tracker.mismatches == 0 && tracker.drained())
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

@@ files.f @@
hdl/bbc_pkg.sv
hdl/bbc_in_if.sv
hdl/bbc_out_if.sv
hdl/bbc_ram.sv
hdl/bbc_datapath.sv
hdl/bbc_ctrl.sv
hdl/bracket_balance_checker.sv
test/tb.sv
